// File: rtl/psbq_pkg.sv
// ----------------------------------------------------------------------------
// psbq_pkg
// Types and constants shared by the per-source token bucket queue.
// ----------------------------------------------------------------------------
package psbq_pkg;

  localparam int unsigned TIME_W        = 48;
  localparam int unsigned LEVEL_W       = 18;
  localparam int unsigned RATE_W        = 10;
  localparam int unsigned BURST_W       = 8;
  localparam int unsigned ELAPSED_W     = 18;
  localparam int unsigned PROD_W        = RATE_W + ELAPSED_W;
  localparam int unsigned SUM_W         = PROD_W + 1;
  localparam int unsigned MILLI         = 1000;
  localparam int unsigned ELAPSED_CLAMP = 262143;
  localparam int unsigned APB_ADDR_W    = 4;
  localparam int unsigned APB_DATA_W    = 32;

  localparam logic               HOST_MODE_RESET = 1'b1;
  localparam logic [RATE_W-1:0]  REFILL_RESET    = 10'd3;
  localparam logic [BURST_W-1:0] BURST_RESET     = 8'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET     = LEVEL_W'(3 * MILLI);

  typedef enum logic [1:0] {
    ACT_ENQUEUE,
    ACT_TICK,
    ACT_PEER_LEFT,
    ACT_DISCONNECT
  } action_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED,
    ST_REFUSED,
    ST_IGNORED,
    ST_DISPATCHED
  } status_e;

  typedef enum logic [1:0] {
    REG_HOST_MODE,
    REG_REFILL,
    REG_BURST
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  slot;
    logic [47:0] now_ms;
    logic [31:0] element_id;
    logic        target_kind;
    logic        tool_kind;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_out;
    logic [31:0] element_id_out;
    logic        target_kind_out;
    logic        tool_kind_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        tool_kind;
    logic        target_kind;
    logic [31:0] element_id;
  } request_t;

  typedef struct packed {
    logic               host_mode;
    logic [RATE_W-1:0]  refill_per_second;
    logic [BURST_W-1:0] burst_tokens;
  } cfg_t;

endpackage

// File: rtl/per_source_token_bucket_queue.sv
// ----------------------------------------------------------------------------
// per_source_token_bucket_queue
// Per-source request FIFOs drained by per-source token buckets.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Every slot's FIFO pointers, token level and last
// refill time sit in a slot state memory, the queued requests in a request
// memory; each action reads the slot state, works on it and writes it back. An
// enqueue passes through a read and a check state to its result (an ignored
// one goes straight to it). A tick walks slots 1 up to PEER_SLOTS-1: an empty
// slot is read and checked, a slot with a queued request is also multiplied
// and added, and a dispatch adds a push; a stalled result stretches this. A
// peer left clears one slot, a disconnect every slot. After reset a clearing
// pass writes every slot of the slot state memory; input is stalled meanwhile.
// ----------------------------------------------------------------------------
module per_source_token_bucket_queue #(
  parameter int unsigned PEER_SLOTS  = 8,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  psbq_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output psbq_pkg::out_item_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [psbq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [psbq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [psbq_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import psbq_pkg::*;

  localparam int unsigned SW    = $clog2(PEER_SLOTS);
  localparam int unsigned HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW    = CW + 1;
  localparam int unsigned RQ_D  = PEER_SLOTS * QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(RQ_D);
  localparam int unsigned RQ_W  = $bits(request_t);

  typedef struct packed {
    logic [HW-1:0]      head;
    logic [CW-1:0]      count;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  last_time;
  } slot_st_t;

  localparam int unsigned ST_W = $bits(slot_st_t);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CHK,
    S_TICK_RD,
    S_TICK_CHK,
    S_TICK_MUL,
    S_TICK_ADD,
    S_TICK_PUSH,
    S_EMIT
  } state_e;

  function automatic logic [AW-1:0] store_addr(logic [SW-1:0] s, logic [HW-1:0] p);
    return AW'(s) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  cfg_t cfg;

  psbq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e             state_q;
  logic [SW-1:0]      cur_q;
  logic               sweep_all_q;
  logic [LEVEL_W-1:0] clr_level_q;
  logic [TIME_W-1:0]  now_q;
  request_t           req_q;
  logic [ELAPSED_W-1:0] el_q;
  logic               refill_ok_q;
  logic [PROD_W-1:0]  prod_q;
  out_item_t          dsp_q;
  out_item_t          pend_q;
  logic               pend_vld_q;
  out_item_t          out_q;
  logic               out_vld_q;

  logic               st_we;
  slot_st_t           st_wdata;
  slot_st_t           st_rdata;
  logic [ST_W-1:0]    st_rdata_raw;
  logic               rq_we;
  logic [AW-1:0]      rq_waddr;
  logic [AW-1:0]      rq_raddr;
  logic [RQ_W-1:0]    rq_rdata_raw;
  request_t           rq_rdata;

  psbq_ram #(.WIDTH(ST_W), .DEPTH(PEER_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (cur_q),
    .wdata_i (st_wdata),
    .raddr_i (cur_q),
    .rdata_o (st_rdata_raw)
  );

  psbq_ram #(.WIDTH(RQ_W), .DEPTH(RQ_D)) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (rq_we),
    .waddr_i (rq_waddr),
    .wdata_i (req_q),
    .raddr_i (rq_raddr),
    .rdata_o (rq_rdata_raw)
  );

  assign st_rdata = slot_st_t'(st_rdata_raw);
  assign rq_rdata = request_t'(rq_rdata_raw);

  logic [PW-1:0]        pos_sum;
  logic [HW-1:0]        pos;
  logic                 full;
  logic [LEVEL_W-1:0]   cap;
  logic [TIME_W-1:0]    elapsed;
  logic                 refill_ok;
  logic [ELAPSED_W-1:0] el_clamped;
  logic [SUM_W-1:0]     lvl_sum;
  logic [LEVEL_W-1:0]   lvl_refill;
  logic                 take;
  logic [HW-1:0]        head_next;
  logic                 out_free;
  logic                 last_slot;
  logic                 out_load;
  out_item_t            out_next;

  always_comb begin
    pos_sum    = PW'(st_rdata.head) + PW'(st_rdata.count);
    pos        = (pos_sum >= PW'(QUEUE_DEPTH)) ? HW'(pos_sum - PW'(QUEUE_DEPTH))
                                               : HW'(pos_sum);
    full       = (st_rdata.count == CW'(QUEUE_DEPTH));
    cap        = LEVEL_W'(cfg.burst_tokens) * LEVEL_W'(MILLI);
    elapsed    = now_q - st_rdata.last_time;
    refill_ok  = (st_rdata.last_time != '0) && (now_q > st_rdata.last_time);
    el_clamped = (elapsed > TIME_W'(ELAPSED_CLAMP)) ? ELAPSED_W'(ELAPSED_CLAMP)
                                                    : elapsed[ELAPSED_W-1:0];
    lvl_sum    = SUM_W'(st_rdata.level) + SUM_W'(prod_q);
    if (!refill_ok_q) begin
      lvl_refill = st_rdata.level;
    end else if (lvl_sum > SUM_W'(cap)) begin
      lvl_refill = cap;
    end else begin
      lvl_refill = lvl_sum[LEVEL_W-1:0];
    end
    take       = (lvl_refill >= LEVEL_W'(MILLI));
    head_next  = (st_rdata.head == HW'(QUEUE_DEPTH - 1)) ? '0 : st_rdata.head + 1'b1;
    out_free   = !out_vld_q || !out_stall_i;
    last_slot  = (cur_q == SW'(PEER_SLOTS - 1));
  end

  always_comb begin
    out_load = pend_vld_q && out_free &&
               (state_q == S_TICK_PUSH || state_q == S_EMIT);
    out_next = pend_q;
    if (state_q == S_EMIT) begin
      out_next.last = 1'b1;
    end
  end

  always_comb begin
    st_we    = 1'b0;
    st_wdata = st_rdata;
    rq_we    = 1'b0;
    rq_waddr = store_addr(cur_q, pos);
    rq_raddr = store_addr(cur_q, st_rdata.head);
    case (state_q)
      S_SWEEP: begin
        st_we              = 1'b1;
        st_wdata.head      = '0;
        st_wdata.count     = '0;
        st_wdata.level     = clr_level_q;
        st_wdata.last_time = '0;
      end
      S_ENQ_CHK: begin
        if (!full) begin
          st_we          = 1'b1;
          rq_we          = 1'b1;
          st_wdata.count = st_rdata.count + 1'b1;
        end
      end
      S_TICK_ADD: begin
        st_we              = 1'b1;
        st_wdata.last_time = now_q;
        if (take) begin
          st_wdata.level = lvl_refill - LEVEL_W'(MILLI);
          st_wdata.head  = head_next;
          st_wdata.count = st_rdata.count - 1'b1;
        end else begin
          st_wdata.level = lvl_refill;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      cur_q       <= '0;
      sweep_all_q <= 1'b1;
      clr_level_q <= LEVEL_RESET;
      now_q       <= '0;
      req_q       <= '0;
      el_q        <= '0;
      refill_ok_q <= 1'b0;
      prod_q      <= '0;
      dsp_q       <= '0;
      pend_q      <= '0;
      pend_vld_q  <= 1'b0;
      out_q       <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_q     <= out_next;
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_SWEEP: begin
          if (!sweep_all_q || last_slot) begin
            state_q <= S_IDLE;
          end else begin
            cur_q <= cur_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            now_q <= in_data_i.now_ms;
            req_q <= '{tool_kind:   in_data_i.tool_kind,
                       target_kind: in_data_i.target_kind,
                       element_id:  in_data_i.element_id};
            case (action_e'(in_data_i.action))
              ACT_ENQUEUE: begin
                if (!cfg.host_mode || in_data_i.slot == 8'd0 ||
                    in_data_i.slot >= 8'(PEER_SLOTS)) begin
                  pend_q     <= '{status: ST_IGNORED, slot_out: in_data_i.slot,
                                  default: '0};
                  pend_vld_q <= 1'b1;
                  state_q    <= S_EMIT;
                end else begin
                  cur_q   <= in_data_i.slot[SW-1:0];
                  state_q <= S_ENQ_RD;
                end
              end
              ACT_TICK: begin
                if (cfg.host_mode) begin
                  cur_q   <= SW'(1);
                  state_q <= S_TICK_RD;
                end
              end
              ACT_PEER_LEFT: begin
                if (in_data_i.slot < 8'(PEER_SLOTS)) begin
                  cur_q       <= in_data_i.slot[SW-1:0];
                  sweep_all_q <= 1'b0;
                  clr_level_q <= cap;
                  state_q     <= S_SWEEP;
                end
              end
              ACT_DISCONNECT: begin
                cur_q       <= '0;
                sweep_all_q <= 1'b1;
                clr_level_q <= cap;
                state_q     <= S_SWEEP;
              end
              default: ;
            endcase
          end
        end
        S_ENQ_RD: begin
          state_q <= S_ENQ_CHK;
        end
        S_ENQ_CHK: begin
          pend_q     <= '{status: full ? ST_REFUSED : ST_ACCEPTED, slot_out: 8'(cur_q),
                          default: '0};
          pend_vld_q <= 1'b1;
          state_q    <= S_EMIT;
        end
        S_TICK_RD: begin
          state_q <= S_TICK_CHK;
        end
        S_TICK_CHK: begin
          if (st_rdata.count == '0) begin
            if (last_slot) begin
              state_q <= S_EMIT;
            end else begin
              cur_q   <= cur_q + 1'b1;
              state_q <= S_TICK_RD;
            end
          end else begin
            el_q        <= el_clamped;
            refill_ok_q <= refill_ok;
            state_q     <= S_TICK_MUL;
          end
        end
        S_TICK_MUL: begin
          prod_q  <= PROD_W'(cfg.refill_per_second) * PROD_W'(el_q);
          state_q <= S_TICK_ADD;
        end
        S_TICK_ADD: begin
          if (take) begin
            dsp_q   <= '{status:          ST_DISPATCHED,
                         slot_out:        8'(cur_q),
                         element_id_out:  rq_rdata.element_id,
                         target_kind_out: rq_rdata.target_kind,
                         tool_kind_out:   rq_rdata.tool_kind,
                         last:            1'b0};
            state_q <= S_TICK_PUSH;
          end else if (last_slot) begin
            state_q <= S_EMIT;
          end else begin
            cur_q   <= cur_q + 1'b1;
            state_q <= S_TICK_RD;
          end
        end
        S_TICK_PUSH: begin
          if (!pend_vld_q || out_free) begin
            pend_q     <= dsp_q;
            pend_vld_q <= 1'b1;
            if (last_slot) begin
              state_q <= S_EMIT;
            end else begin
              cur_q   <= cur_q + 1'b1;
              state_q <= S_TICK_RD;
            end
          end
        end
        S_EMIT: begin
          if (!pend_vld_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            pend_vld_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_vld_q)
    else $error("pending result left behind when idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> st_wdata.count <= CW'(QUEUE_DEPTH))
    else $error("queue count written beyond depth");

  a_dispatch_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status == ST_DISPATCHED |->
      out_q.slot_out != 8'd0 && out_q.slot_out < 8'(PEER_SLOTS))
    else $error("dispatch for a slot outside the scanned range");

endmodule

// File: rtl/psbq_ram.sv
// ----------------------------------------------------------------------------
// psbq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psbq_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/psbq_regs.sv
// ----------------------------------------------------------------------------
// psbq_regs
// APB register file: host mode, refill rate and burst size.
// ----------------------------------------------------------------------------
module psbq_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psbq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [psbq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [psbq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output psbq_pkg::cfg_t                      cfg_o
);
  import psbq_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{host_mode:         HOST_MODE_RESET,
                 refill_per_second: REFILL_RESET,
                 burst_tokens:      BURST_RESET};
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_HOST_MODE: cfg_q.host_mode         <= pwdata[0];
        REG_REFILL:    cfg_q.refill_per_second <= pwdata[RATE_W-1:0];
        REG_BURST:     cfg_q.burst_tokens      <= pwdata[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HOST_MODE: prdata = APB_DATA_W'(cfg_q.host_mode);
      REG_REFILL:    prdata = APB_DATA_W'(cfg_q.refill_per_second);
      REG_BURST:     prdata = APB_DATA_W'(cfg_q.burst_tokens);
      default:       prdata = '0;
    endcase
  end

endmodule
